/* sv/pms_pkg.sv */
// Shared types and constants for the PN multipath separator.
// No dependencies; imported by every module of the block.
package pms_pkg;

	// Store word: Q8 sample that grows through path subtraction
	localparam int SAMPLE_W   = 40;
	localparam int Q_FRAC     = 8;
	localparam int Q_ONE      = 256;
	localparam int THR_W      = 24;
	localparam int DELAY_W    = 11;
	localparam int AMP_W      = 32;
	localparam int RESULT_CAP = 16;

	// Chip generator: 11-cell feedback register, taps 6, 9 and 10
	localparam int          LFSR_W    = 11;
	localparam logic [10:0] LFSR_SEED = 11'h001;

	localparam logic [AMP_W-1:0] AMP_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_sample;
	} item_t;

	typedef struct packed {
		logic [DELAY_W-1:0]      path_delay;
		logic signed [AMP_W-1:0] path_amplitude;
		logic                    path_found;
		logic                    last_path;
	} result_t;

	// Control broadcast to every correlator cell
	typedef struct packed {
		logic clr;
		logic step;
		logic shift;
	} cell_ctrl_t;

	// One step of the chip generator; the chip is bit 10 before the step
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
		return {s[9:0], s[6] ^ s[9] ^ s[10]};
	endfunction

endpackage

/* sv/pn_multipath_separator.sv */
// Top level of the PN multipath separator: capture store, search control,
// path subtraction and result output. Depends on pms_pkg, pms_chain, pms_div.
//
// Samples are taken one per cycle while busy is low; the one marked
// last_sample starts the search and busy stays high until the capture store
// has been cleared again. One search pass runs ceil(LAGS/NUM_CELLS) blocks,
// each streaming the store through the cell chain and then reading the
// cells out, where LAGS = CAPTURE_LEN-SEQ_LEN; the chain of correlator
// cells and the single store read port set this schedule.
// Each reported path adds a division by reciprocal multiplication and a
// store update, and the pass repeats per path. After the final result the
// store is cleared, and likewise after reset. Results appear for one cycle
// on result_strobe and cannot be held off; a capture gives one to
// min(MAX_PATHS,16) results, the last with last_path set.
module pn_multipath_separator
	import pms_pkg::*;
#(
	parameter int SEQ_LEN     = 1023,
	parameter int CAPTURE_LEN = 2048,
	parameter int MAX_PATHS   = 16,
	parameter int NUM_CELLS   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  item_t            item,
	output logic             busy,
	output logic             result_strobe,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [THR_W-1:0] cfg_data
);

	localparam int LAGS       = (CAPTURE_LEN > SEQ_LEN) ? CAPTURE_LEN - SEQ_LEN : 0;
	localparam int PATH_LIMIT = (MAX_PATHS < RESULT_CAP) ? MAX_PATHS : RESULT_CAP;
	localparam int STREAM_LEN = NUM_CELLS + SEQ_LEN - 1;
	localparam int ACC_W      = SAMPLE_W + $clog2(SEQ_LEN) + 1;
	localparam int AW         = $clog2(CAPTURE_LEN);
	localparam int WIW        = $clog2(CAPTURE_LEN + 1);
	localparam int XW         = $clog2(CAPTURE_LEN + STREAM_LEN + NUM_CELLS + 1);
	localparam int TW         = $clog2(STREAM_LEN + 1);
	localparam int JW         = $clog2(NUM_CELLS + 1);
	localparam int SW         = $clog2(SEQ_LEN + 1);
	localparam int PW         = $clog2(PATH_LIMIT + 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_SRCH, ST_BLK, ST_STRM, ST_READ,
		ST_DIVS, ST_DIVW, ST_DEC, ST_SUB, ST_FIN
	} state_t;

	state_t                    state_q;
	logic [THR_W-1:0]          thr_q;
	logic [WIW-1:0]            wr_idx_q;
	logic [AW-1:0]             clr_cnt_q;
	logic [XW-1:0]             base_q;
	logic [TW-1:0]             t_q;
	logic [TW-1:0]             t_s1;
	logic                      strm_vld_s1;
	logic                      rng_s1;
	logic [JW-1:0]             j_q;
	logic [LFSR_W-1:0]         lfsr_q;
	logic signed [ACC_W-1:0]   best_q;
	logic [AW-1:0]             best_lag_q;
	logic [ACC_W-1:0]          amp_q;
	logic [SW-1:0]             sub_i_q;
	logic                      sub_vld_s1;
	logic [AW-1:0]             sub_addr_s1;
	logic                      sub_chip_s1;
	logic [PW-1:0]             paths_q;
	logic                      pend_vld_q;
	result_t                   pend_q;
	result_t                   res_q;
	logic                      res_strobe_q;

	logic [SAMPLE_W-1:0]       store_mem [CAPTURE_LEN];
	logic [SAMPLE_W-1:0]       rd_data_q;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [SAMPLE_W-1:0]       mem_wdata;
	logic [AW-1:0]             mem_raddr;

	logic [XW-1:0]             strm_addr;
	logic                      strm_issue;
	logic [XW-1:0]             read_lag;
	logic [XW-1:0]             next_base;
	logic [XW-1:0]             sub_addr;
	logic                      sub_issue;
	logic                      accept;
	logic [SAMPLE_W-1:0]       sample_q8;
	cell_ctrl_t                ctrl;
	logic signed [SAMPLE_W-1:0] chain_sample;
	logic                      inj_vld;
	logic signed [ACC_W-1:0]   head_acc;
	logic                      div_start;
	logic                      div_done;
	logic [ACC_W-1:0]          div_quo;
	logic                      path_ok;
	logic [AMP_W-1:0]          amp_sat;
	result_t                   new_path;
	result_t                   no_path;

	assign busy          = (state_q != ST_IDLE);
	assign accept        = start && !busy;
	assign cfg_ready     = 1'b1;
	assign result_strobe = res_strobe_q;
	assign result        = res_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// address and lag arithmetic
	assign strm_addr  = base_q + XW'(t_q);
	assign strm_issue = (state_q == ST_STRM) && (t_q != TW'(STREAM_LEN));
	assign read_lag   = base_q + XW'(j_q);
	assign next_base  = base_q + XW'(NUM_CELLS);
	assign sub_addr   = XW'(best_lag_q) + XW'(sub_i_q);
	assign sub_issue  = (state_q == ST_SUB) && (sub_i_q != SW'(SEQ_LEN));
	assign sample_q8  = {{(SAMPLE_W-16-Q_FRAC){item.sample[15]}}, item.sample,
		{Q_FRAC{1'b0}}};

	// store port muxing: capture, update and clear never overlap
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_we    = accept && (wr_idx_q < WIW'(CAPTURE_LEN));
				mem_waddr = wr_idx_q[AW-1:0];
				mem_wdata = sample_q8;
			end
			ST_SUB: begin
				mem_we    = sub_vld_s1;
				mem_waddr = sub_addr_s1;
				mem_wdata = sub_chip_s1 ? rd_data_q - amp_q[SAMPLE_W-1:0]
					: rd_data_q + amp_q[SAMPLE_W-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		mem_raddr = (state_q == ST_SUB) ? sub_addr[AW-1:0] : strm_addr[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= store_mem[mem_raddr];
	end

	// correlator chain feed
	assign ctrl.clr     = (state_q == ST_BLK);
	assign ctrl.step    = strm_vld_s1;
	assign ctrl.shift   = (state_q == ST_READ);
	assign chain_sample = rng_s1 ? rd_data_q : '0;
	assign inj_vld      = strm_vld_s1 && (t_s1 < TW'(SEQ_LEN));

	pms_chain #(
		.NUM_CELLS(NUM_CELLS),
		.ACC_W    (ACC_W)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.sample  (chain_sample),
		.chip_in (lfsr_q[LFSR_W-1]),
		.cvld_in (inj_vld),
		.head_acc(head_acc)
	);

	// amplitude = best sum / SEQ_LEN, only ever for a positive sum
	assign div_start = (state_q == ST_DIVS) && (best_q > 0);

	pms_div #(
		.DW     (ACC_W),
		.DIVISOR(SEQ_LEN)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(best_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// path decision and result words
	assign path_ok = (amp_q > ACC_W'(thr_q)) && (amp_q != '0);
	assign amp_sat = (amp_q > ACC_W'(AMP_MAX)) ? AMP_MAX : amp_q[AMP_W-1:0];

	always_comb begin
		new_path.path_delay     = DELAY_W'(best_lag_q);
		new_path.path_amplitude = amp_sat;
		new_path.path_found     = 1'b1;
		new_path.last_path      = 1'b0;
		no_path                 = '0;
		no_path.last_path       = 1'b1;
	end

	// control sequencer with registered result output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			wr_idx_q     <= '0;
			strm_vld_s1  <= 1'b0;
			sub_vld_s1   <= 1'b0;
			pend_vld_q   <= 1'b0;
			paths_q      <= '0;
			res_strobe_q <= 1'b0;
			t_q          <= '0;
			j_q          <= '0;
			sub_i_q      <= '0;
			base_q       <= '0;
			lfsr_q       <= LFSR_SEED;
		end else begin
			// strobe on a flushed pending path or on the final result
			res_strobe_q <= ((state_q == ST_DEC) && path_ok && pend_vld_q)
				|| (state_q == ST_FIN);
			strm_vld_s1  <= strm_issue;
			t_s1         <= t_q;
			rng_s1       <= strm_addr < XW'(CAPTURE_LEN);
			sub_vld_s1   <= sub_issue;
			sub_addr_s1  <= sub_addr[AW-1:0];
			sub_chip_s1  <= lfsr_q[LFSR_W-1];
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(CAPTURE_LEN - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (wr_idx_q < WIW'(CAPTURE_LEN)) begin
							wr_idx_q <= wr_idx_q + 1'b1;
						end
						if (item.last_sample) begin
							paths_q    <= '0;
							pend_vld_q <= 1'b0;
							state_q    <= (LAGS > 0) ? ST_SRCH : ST_FIN;
						end
					end
				end
				ST_SRCH: begin
					best_q     <= ACC_W'(-Q_ONE);
					best_lag_q <= '0;
					base_q     <= '0;
					state_q    <= ST_BLK;
				end
				ST_BLK: begin
					lfsr_q  <= LFSR_SEED;
					t_q     <= '0;
					state_q <= ST_STRM;
				end
				ST_STRM: begin
					if (strm_issue) begin
						t_q <= t_q + 1'b1;
					end
					if (inj_vld) begin
						lfsr_q <= lfsr_next(lfsr_q);
					end
					if (!strm_issue && !strm_vld_s1) begin
						j_q     <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// earliest lag wins ties: strictly larger only
					if ((read_lag < XW'(LAGS)) && (head_acc > best_q)) begin
						best_q     <= head_acc;
						best_lag_q <= read_lag[AW-1:0];
					end
					j_q <= j_q + 1'b1;
					if (j_q == JW'(NUM_CELLS - 1)) begin
						base_q  <= next_base;
						state_q <= (next_base >= XW'(LAGS)) ? ST_DIVS : ST_BLK;
					end
				end
				ST_DIVS: begin
					state_q <= (best_q > 0) ? ST_DIVW : ST_FIN;
				end
				ST_DIVW: begin
					if (div_done) begin
						amp_q   <= div_quo;
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (path_ok) begin
						if (pend_vld_q) begin
							res_q <= pend_q;
						end
						pend_q     <= new_path;
						pend_vld_q <= 1'b1;
						paths_q    <= paths_q + 1'b1;
						lfsr_q     <= LFSR_SEED;
						sub_i_q    <= '0;
						state_q    <= ST_SUB;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SUB: begin
					if (sub_issue) begin
						sub_i_q <= sub_i_q + 1'b1;
						lfsr_q  <= lfsr_next(lfsr_q);
					end
					if (!sub_issue && !sub_vld_s1) begin
						state_q <= (paths_q == PW'(PATH_LIMIT)) ? ST_FIN : ST_SRCH;
					end
				end
				ST_FIN: begin
					if (pend_vld_q) begin
						res_q <= {pend_q.path_delay, pend_q.path_amplitude,
							pend_q.path_found, 1'b1};
					end else begin
						res_q <= no_path;
					end
					pend_vld_q   <= 1'b0;
					wr_idx_q     <= '0;
					clr_cnt_q    <= '0;
					state_q      <= ST_CLEAR;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

/* sv/pms_cell.sv */
// One correlator cell: accumulates the broadcast sample against the chip it
// receives, and passes that chip to its neighbor. Depends on pms_pkg.
module pms_cell
	import pms_pkg::*;
#(
	parameter int ACC_W = 51
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       chip_in,
	input  logic                       cvld_in,
	input  logic signed [ACC_W-1:0]    acc_in,
	output logic                       chip_q,
	output logic                       cvld_q,
	output logic signed [ACC_W-1:0]    acc_q
);

	logic signed [ACC_W-1:0] sample_ext;

	assign sample_ext = {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};

	// chip hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q <= 1'b0;
			chip_q <= 1'b0;
		end else if (ctrl.clr) begin
			cvld_q <= 1'b0;
		end else if (ctrl.step) begin
			cvld_q <= cvld_in;
			chip_q <= chip_in;
		end
	end

	// accumulate, or shift toward the head of the chain for readout
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.step && cvld_in) begin
			acc_q <= chip_in ? acc_q + sample_ext : acc_q - sample_ext;
		end else if (ctrl.shift) begin
			acc_q <= acc_in;
		end
	end

endmodule

/* sv/pms_chain.sv */
// Row of correlator cells; cell k computes the sum for lag base + k.
// Depends on pms_pkg and pms_cell.
module pms_chain
	import pms_pkg::*;
#(
	parameter int NUM_CELLS = 32,
	parameter int ACC_W     = 51
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       chip_in,
	input  logic                       cvld_in,
	output logic signed [ACC_W-1:0]    head_acc
);

	logic                    chip_w [NUM_CELLS+1];
	logic                    cvld_w [NUM_CELLS+1];
	logic signed [ACC_W-1:0] acc_w  [NUM_CELLS+1];

	assign chip_w[0]         = chip_in;
	assign cvld_w[0]         = cvld_in;
	assign acc_w[NUM_CELLS]  = '0;
	assign head_acc          = acc_w[0];

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		pms_cell #(
			.ACC_W(ACC_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sample (sample),
			.chip_in(chip_w[k]),
			.cvld_in(cvld_w[k]),
			.acc_in (acc_w[k+1]),
			.chip_q (chip_w[k+1]),
			.cvld_q (cvld_w[k+1]),
			.acc_q  (acc_w[k])
		);
	end

endmodule

/* sv/pms_div.sv */
// Division by a fixed divisor through reciprocal multiplication.
// Depends on pms_pkg for the shared import style only.
module pms_div
	import pms_pkg::*;
#(
	parameter int DW      = 51,
	parameter int DIVISOR = 1023
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	output logic          done,
	output logic [DW-1:0] quotient
);

	// q = (x * RECIP) >> SH is exact for every x below 2^DW
	localparam int           SH    = DW + $clog2(DIVISOR);
	localparam logic [127:0] RECIP = ((128'd1 << SH) + 128'(DIVISOR - 1)) / 128'(DIVISOR);
	// product built from CH x CH partial products, one per cycle
	localparam int           CH    = 27;
	localparam int           NX    = (DW + CH - 1) / CH;
	localparam int           NM    = (DW + 2 + CH - 1) / CH;
	localparam int           XPW   = NX * CH;
	localparam int           MPW   = NM * CH;
	localparam int           PWD   = XPW + MPW;
	localparam int           XIW   = $clog2(NX + 1);
	localparam int           MIW   = $clog2(NM + 1);

	logic [XPW-1:0]  x_q;
	logic [MPW-1:0]  recip_w;
	logic [PWD-1:0]  acc_q;
	logic [XIW-1:0]  ix_q;
	logic [MIW-1:0]  im_q;
	logic            run_q;
	logic            done_q;
	logic            last_dig;
	logic [CH-1:0]   x_dig;
	logic [CH-1:0]   m_dig;
	logic [2*CH-1:0] part;

	assign recip_w  = RECIP[MPW-1:0];
	assign x_dig    = x_q[ix_q*CH +: CH];
	assign m_dig    = recip_w[im_q*CH +: CH];
	assign part     = x_dig * m_dig;
	assign last_dig = (ix_q == XIW'(NX - 1)) && (im_q == MIW'(NM - 1));
	assign done     = done_q;
	assign quotient = DW'(acc_q >> SH);

	// partial product sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ix_q   <= '0;
			im_q   <= '0;
		end else begin
			done_q <= run_q && !start && last_dig;
			if (start) begin
				run_q <= 1'b1;
				ix_q  <= '0;
				im_q  <= '0;
			end else if (run_q) begin
				if (im_q == MIW'(NM - 1)) begin
					im_q <= '0;
					ix_q <= ix_q + 1'b1;
				end else begin
					im_q <= im_q + 1'b1;
				end
				if (last_dig) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// accumulate each shifted partial product
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= XPW'(dividend);
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + (PWD'(part) << ((ix_q + im_q) * CH));
		end
	end

endmodule

/* sv/pms_checker.sv */
// Port-level checks for the PN multipath separator, bound to the top level.
// Depends on pms_pkg and pn_multipath_separator.
module pms_checker
	import pms_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input item_t   item,
	input logic    busy,
	input logic    result_strobe,
	input result_t result
);

	// results appear only while a capture is being processed
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result outside processing");

	// the final sample of a capture starts processing
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last_sample) |=> busy)
		else $error("capture end did not start processing");

	// a no-path result is the only and final one, and carries zeros
	a_nopath: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.path_found) |->
		(result.last_path && result.path_amplitude == 0 && result.path_delay == 0))
		else $error("malformed no-path result");

	// reported paths always have a positive amplitude
	a_amp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.path_found) |-> (result.path_amplitude > 0))
		else $error("path with non-positive amplitude");

endmodule

bind pn_multipath_separator pms_checker u_pms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result_strobe(result_strobe),
	.result       (result)
);

/* dv/pn_multipath_separator_tb.sv */
// Self-checking testbench for pn_multipath_separator: a directed table, then random captures.
// Depends on pms_pkg and the RTL only; it predicts results with its own correlator model.
`timescale 1ns / 100ps

module pn_multipath_separator_tb;
	import pms_pkg::*;

	localparam int SEQ_N    = 1023;
	localparam int CAP_N    = 2048;
	localparam int PATH_MAX = 16;
	localparam int WD_LIMIT = 400000;
	localparam int N_RANDOM = 220;

	logic             clk;
	logic             arst_n;
	logic             start;
	item_t            item;
	logic             busy;
	logic             result_strobe;
	result_t          result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [THR_W-1:0] cfg_data;

	pn_multipath_separator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.result_strobe(result_strobe), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Directed stimulus row; exp_known marks a typed-in expectation
	typedef struct {
		logic signed [15:0] smp;
		logic               fin;
		bit                 exp_known;
		result_t            exp;
	} row_t;

	longint    cap_store[CAP_N];
	bit        chip_seq[SEQ_N];
	int        cap_fill;
	longint    thr;
	result_t   path_q[$];
	int        errors;
	int        quiet_cycles;
	int        idle_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what);
		errors++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	function automatic longint corr_at(input int lag);
		longint acc;
		acc = 0;
		for (int i = 0; i < SEQ_N; i++)
			acc = chip_seq[i] ? acc + cap_store[lag + i] : acc - cap_store[lag + i];
		return acc;
	endfunction

	// Successive cancellation over the current capture; queues the paths it finds
	task automatic separate_capture();
		result_t found[$];
		result_t r;
		longint  best, c, amp;
		int      best_lag;
		logic signed [SAMPLE_W-1:0] w;
		while (found.size() < PATH_MAX) begin
			best = -Q_ONE;
			best_lag = 0;
			for (int lag = 0; lag < CAP_N - SEQ_N; lag++) begin
				c = corr_at(lag);
				if (c > best) begin
					best = c;
					best_lag = lag;
				end
			end
			amp = corr_at(best_lag) / SEQ_N;
			if (!(amp > thr && amp > 0))
				break;
			r.path_delay = best_lag[DELAY_W-1:0];
			r.path_amplitude = (amp > 64'sd2147483647) ? 32'h7FFF_FFFF : amp[31:0];
			r.path_found = 1'b1;
			r.last_path = 1'b0;
			found.push_back(r);
			for (int i = 0; i < SEQ_N; i++) begin
				w = SAMPLE_W'(chip_seq[i] ? cap_store[best_lag + i] - amp
					: cap_store[best_lag + i] + amp);
				cap_store[best_lag + i] = w;
			end
		end
		if (found.size() == 0) begin
			r = '0;
			r.last_path = 1'b1;
			found.push_back(r);
		end else begin
			found[found.size() - 1].last_path = 1'b1;
		end
		foreach (found[k])
			path_q.push_back(found[k]);
		for (int i = 0; i < CAP_N; i++)
			cap_store[i] = 0;
		cap_fill = 0;
	endtask

	// Store one accepted sample; a final sample runs the search
	task automatic take_sample(input item_t it, input bit use_model);
		if (cap_fill < CAP_N) begin
			cap_store[cap_fill] = longint'(it.sample) * Q_ONE;
			cap_fill++;
		end
		if (it.last_sample) begin
			if (use_model) begin
				separate_capture();
			end else begin
				// typed-in row: the block still clears its store
				for (int i = 0; i < CAP_N; i++)
					cap_store[i] = 0;
				cap_fill = 0;
			end
		end
	endtask

	// Present one request and hold it until the block takes it
	task automatic send(input item_t it, input bit use_model);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		take_sample(it, use_model);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (path_q.size() != 0)
			@(posedge clk);
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		bit taken;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		thr = longint'(v);
	endtask

	// Result checker and inactivity watchdog
	always @(negedge clk) begin
		result_t e;
		if (arst_n) begin
			if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
		if (result_strobe) begin
			if (path_q.size() == 0) begin
				report("result with none expected");
			end else begin
				e = path_q.pop_front();
				if (result.path_delay !== e.path_delay)
					report($sformatf("path_delay %0d exp %0d", result.path_delay, e.path_delay));
				if (result.path_amplitude !== e.path_amplitude)
					report($sformatf("path_amplitude %0d exp %0d",
						result.path_amplitude, e.path_amplitude));
				if (result.path_found !== e.path_found)
					report($sformatf("path_found %0b exp %0b", result.path_found, e.path_found));
				if (result.last_path !== e.last_path)
					report($sformatf("last_path %0b exp %0b", result.last_path, e.last_path));
			end
		end
	end

	initial begin
		row_t    rows[$];
		row_t    rw;
		item_t   it;
		logic [10:0] cells;
		int      sent, len;
		int      phase_idle[5];
		logic [THR_W-1:0] phase_thr[5];

		errors = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		thr = 0;
		cap_fill = 0;
		for (int i = 0; i < CAP_N; i++)
			cap_store[i] = 0;
		// chip sequence from the 11-cell generator
		cells = 11'h001;
		for (int i = 0; i < SEQ_N; i++) begin
			chip_seq[i] = cells[10];
			cells = {cells[9:0], cells[6] ^ cells[9] ^ cells[10]};
		end

		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table: zero capture, extremes, short and multi-sample captures
		rw = '{smp: 16'sd0, fin: 1'b1, exp_known: 1, exp: '{0, 0, 1'b0, 1'b1}};
		rows.push_back(rw);
		rw.exp_known = 0;
		rw.smp = 16'sh7FFF; rw.fin = 1'b1; rows.push_back(rw);
		rw.smp = -16'sh8000; rw.fin = 1'b1; rows.push_back(rw);
		rw.smp = 16'sd0; rw.fin = 1'b0; rows.push_back(rw);
		rw.smp = -16'sh8000; rw.fin = 1'b1; rows.push_back(rw);
		rw.smp = 16'sh7FFF; rw.fin = 1'b0; rows.push_back(rw);
		rw.smp = 16'sh7FFF; rw.fin = 1'b0; rows.push_back(rw);
		rw.smp = -16'sh8000; rw.fin = 1'b1; rows.push_back(rw);
		rw.smp = -16'sd1; rw.fin = 1'b0; rows.push_back(rw);
		rw.smp = 16'sd1; rw.fin = 1'b0; rows.push_back(rw);
		rw.smp = 16'sh5555; rw.fin = 1'b0; rows.push_back(rw);
		rw.smp = -16'sh2AAB; rw.fin = 1'b1; rows.push_back(rw);
		// cleared store after a capture: a lone zero again finds nothing
		rw = '{smp: 16'sd0, fin: 1'b1, exp_known: 1, exp: '{0, 0, 1'b0, 1'b1}};
		rows.push_back(rw);
		foreach (rows[r]) begin
			it.sample = rows[r].smp;
			it.last_sample = rows[r].fin;
			send(it, !rows[r].exp_known);
			if (rows[r].exp_known)
				path_q.push_back(rows[r].exp);
		end
		// hold off until the table has fully drained
		wait_idle();

		// Random captures over several thresholds and sender idling
		phase_thr = '{24'd0, 24'hFFFFFF, 24'd20000, 24'd1, 24'd0};
		phase_idle = '{0, 52, 16, 52, 0};
		phase_thr[3] = THR_W'($urandom_range(24'hFFFFFF));
		sent = 0;
		for (int p = 0; p < 5; p++) begin
			write_threshold(phase_thr[p]);
			idle_pct = phase_idle[p];
			while (sent < (p + 1) * N_RANDOM / 5) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(3))
						0: it.sample = 16'($urandom);
						1: it.sample = 16'($urandom_range(255)) - 16'sd128;
						2: it.sample = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
						default: it.sample = 16'($urandom_range(32767));
					endcase
					it.last_sample = (i == len - 1);
					send(it, 1);
					sent++;
				end
			end
		end
		write_threshold(24'd0);

		wait_idle();
		repeat (CAP_N + 100) @(posedge clk);
		if (errors == 0 && path_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
